### rtl/rectangle_raster_fill_core_macros.svh
// assertion macros for the rectangle raster fill core
`ifndef RECTANGLE_RASTER_FILL_CORE_MACROS_SVH
`define RECTANGLE_RASTER_FILL_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define RRF_ASSERT_IMPL(lbl, clk_s, rst_s, a, b) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |-> (b)) \
        else $error("rrf check failed");

`define RRF_ASSERT_NEXT(lbl, clk_s, rst_s, a, b) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |=> (b)) \
        else $error("rrf check failed");

`else

`define RRF_ASSERT_IMPL(lbl, clk_s, rst_s, a, b)

`define RRF_ASSERT_NEXT(lbl, clk_s, rst_s, a, b)

`endif

`endif

### rtl/rrf_pkg.sv
`timescale 1ns / 1ps

package rrf_pkg;

    localparam int MAX_SIDE_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;

    localparam int COORD_W = 20;
    localparam int CFG_W   = 9;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 8;

    // input tdata layout, lowest bit first
    localparam int IN_X_LSB       = 0;
    localparam int IN_Y_LSB       = 20;
    localparam int IN_W_LSB       = 40;
    localparam int IN_H_LSB       = 60;
    localparam int IN_OUTLINE_BIT = 80;
    localparam int IN_COLOR_LSB   = 81;
    localparam int IN_ROW_LSB     = 89;
    localparam int IN_COL_LSB     = 97;
    localparam int IN_DATA_W      = 112;
    localparam int OUT_DATA_W     = 16;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SIZE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_WIDTH      = 2'd0;
    localparam logic [1:0] REG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_BACKGROUND = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RST      = 9'd1;
    localparam logic [CFG_W-1:0] HEIGHT_RST     = 9'd1;
    localparam logic [PIX_W-1:0] BACKGROUND_RST = 8'd32;

    // bound slots per axis: low edge, low edge plus one, high edge, high edge minus one
    localparam int B_LO   = 0;
    localparam int B_IN   = 1;
    localparam int B_HI   = 2;
    localparam int B_BAND = 3;
    localparam int BOUND_N = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_BAND,
        S_SWEEP,
        S_RDADDR,
        S_RDMEM,
        S_DONE
    } rrf_state_t;

    typedef struct packed {
        logic in_rect;
        logic border;
    } cover_t;

endpackage

### rtl/rrf_cover.sv
`timescale 1ns / 1ps

module rrf_cover #(
    parameter int IDX_W     = 8,
    parameter int FRAC_BITS = 8,
    parameter int CW        = 22
) (
    input  logic [IDX_W-1:0]     col,
    input  logic [IDX_W-1:0]     row,
    input  logic signed [CW-1:0] xb [rrf_pkg::BOUND_N],
    input  logic signed [CW-1:0] yb [rrf_pkg::BOUND_N],
    output rrf_pkg::cover_t      cov
);
    import rrf_pkg::*;

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 in_x;
    logic                 in_y;
    logic                 band;

    always_comb
    begin
        px   = CW'(col) << FRAC_BITS;
        py   = CW'(row) << FRAC_BITS;
        in_x = (px >= xb[B_LO]) && (px <= xb[B_HI]);
        in_y = (py >= yb[B_LO]) && (py <= yb[B_HI]);
        // less than one unit from any edge
        band = (px < xb[B_IN]) || (px > xb[B_BAND]) ||
               (py < yb[B_IN]) || (py > yb[B_BAND]);
        cov.in_rect = in_x && in_y;
        cov.border  = in_x && in_y && band;
    end

endmodule

### rtl/rectangle_raster_fill_core.sv
`timescale 1ns / 1ps
`include "rectangle_raster_fill_core_macros.svh"

// Byte framebuffer of MAX_SIDE x MAX_SIDE pixels with clear, rectangle draw and
// pixel read, one result transfer per input transfer. Clear and draw sweep the
// active frame one pixel per cycle through a single memory write port, and draw
// decides each pixel in a single coverage compare unit. A draw of rejected size
// and an unused action answer without a sweep, and a read outside the frame
// answers without a memory read. The input is not ready while an item is in
// work; a finished result sits in an output register so the next item can be
// taken meanwhile. The frame memory is not initialised at reset: read only
// pixels that a clear or draw has written. Registers: 0 frame width, 1 frame
// height, 2 background byte; sizes of 0 act as 1 and sizes above MAX_SIDE act
// as MAX_SIDE.
module rectangle_raster_fill_core #(
    parameter int MAX_SIDE  = rrf_pkg::MAX_SIDE_DEF,
    parameter int FRAC_BITS = rrf_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // rect_x, rect_y, rect_width, rect_height, outline, color, read_row, read_col
    input  logic [rrf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // action
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status, pixel
    output logic [rrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [rrf_pkg::CFG_W-1:0]     cfg_data
);
    import rrf_pkg::*;

    localparam int IDX_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PROD_W    = ADDR_W + CFG_W;
    localparam int CMP_W     = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
    localparam int CW        = (IDX_W + FRAC_BITS + 1 > 22) ? IDX_W + FRAC_BITS + 1 : 22;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

    // state and control
    rrf_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // configuration
    logic [CFG_W-1:0] fw_reg, fh_reg;
    logic [PIX_W-1:0] bg_reg;

    // item fields
    logic [1:0]                act_reg, act_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [COORD_W-1:0] w_reg, w_next;
    logic signed [COORD_W-1:0] h_reg, h_next;
    logic                      outline_reg, outline_next;
    logic [PIX_W-1:0]          color_reg, color_next;
    logic [POS_W-1:0]          rrow_reg, rrow_next;
    logic [POS_W-1:0]          rcol_reg, rcol_next;

    // datapath
    logic signed [CW-1:0] xb_reg [BOUND_N];
    logic signed [CW-1:0] xb_next [BOUND_N];
    logic signed [CW-1:0] yb_reg [BOUND_N];
    logic signed [CW-1:0] yb_next [BOUND_N];
    logic [IDX_W-1:0]     col_reg, col_next;
    logic [IDX_W-1:0]     row_reg, row_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic                 res_rd_reg, res_rd_next;
    logic [PIX_W-1:0]     rdata_reg;
    logic [1:0]           out_status_reg, out_status_next;
    logic [PIX_W-1:0]     out_pixel_reg, out_pixel_next;

    logic [PIX_W-1:0] mem [MEM_DEPTH];

    logic [SIDE_W-1:0]         w_act, h_act;
    logic                      s_xfer, out_free;
    logic                      last_col, last_row;
    logic                      outside;
    logic                      size_bad;
    logic signed [COORD_W-1:0] in_w, in_h;
    cover_t                    cov;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [PIX_W-1:0]          wr_data;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (CMP_W'(v) > CMP_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    assign w_act    = clamp_side(fw_reg);
    assign h_act    = clamp_side(fh_reg);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign last_col = (SIDE_W'(col_reg) == w_act - SIDE_W'(1));
    assign last_row = (SIDE_W'(row_reg) == h_act - SIDE_W'(1));
    assign in_w     = s_axis_tdata[IN_W_LSB +: COORD_W];
    assign in_h     = s_axis_tdata[IN_H_LSB +: COORD_W];
    assign size_bad = in_w[COORD_W-1] || (in_w == '0) || in_h[COORD_W-1] || (in_h == '0);
    assign outside  = (CMP_W'(rrow_reg) >= CMP_W'(h_act)) ||
                      (CMP_W'(rcol_reg) >= CMP_W'(w_act));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_pixel_reg, out_status_reg};
    assign cfg_ready     = 1'b1;

    rrf_cover #(
        .IDX_W     (IDX_W),
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_cover (
        .col (col_reg),
        .row (row_reg),
        .xb  (xb_reg),
        .yb  (yb_reg),
        .cov (cov)
    );

    // pixel write for the sweep
    always_comb
    begin
        wr_addr = base_reg + ADDR_W'(col_reg);
        wr_data = (act_reg == ACT_CLEAR) ? bg_reg : color_reg;
        wr_en   = (state_reg == S_SWEEP) &&
                  ((act_reg == ACT_CLEAR) || (outline_reg ? cov.border : cov.in_rect));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    case (s_axis_tuser)
                        ACT_CLEAR: state_next = S_SWEEP;
                        ACT_DRAW:  state_next = size_bad ? S_DONE : S_EDGE;
                        ACT_READ:  state_next = S_RDADDR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_EDGE:   state_next = S_BAND;
            S_BAND:   state_next = S_SWEEP;
            S_SWEEP:
            begin
                if (last_col && last_row)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDADDR: state_next = outside ? S_DONE : S_RDMEM;
            S_RDMEM:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        act_next        = act_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        outline_next    = outline_reg;
        color_next      = color_reg;
        rrow_next       = rrow_reg;
        rcol_next       = rcol_reg;
        xb_next         = xb_reg;
        yb_next         = yb_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        out_status_next = out_status_reg;
        out_pixel_next  = out_pixel_reg;
        out_valid_next  = m_axis_tready ? 1'b0 : out_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    act_next        = s_axis_tuser;
                    x_next          = s_axis_tdata[IN_X_LSB +: COORD_W];
                    y_next          = s_axis_tdata[IN_Y_LSB +: COORD_W];
                    w_next          = in_w;
                    h_next          = in_h;
                    outline_next    = s_axis_tdata[IN_OUTLINE_BIT];
                    color_next      = s_axis_tdata[IN_COLOR_LSB +: PIX_W];
                    rrow_next       = s_axis_tdata[IN_ROW_LSB +: POS_W];
                    rcol_next       = s_axis_tdata[IN_COL_LSB +: POS_W];
                    col_next        = '0;
                    row_next        = '0;
                    base_next       = '0;
                    res_rd_next     = 1'b0;
                    res_status_next = ((s_axis_tuser == ACT_DRAW) && size_bad) ? ST_SIZE : ST_OK;
                end
            end
            S_EDGE:
            begin
                xb_next[B_LO] = CW'(x_reg);
                xb_next[B_IN] = CW'(x_reg) + ONE_C;
                xb_next[B_HI] = CW'(x_reg) + CW'(w_reg);
                yb_next[B_LO] = CW'(y_reg);
                yb_next[B_IN] = CW'(y_reg) + ONE_C;
                yb_next[B_HI] = CW'(y_reg) + CW'(h_reg);
            end
            S_BAND:
            begin
                xb_next[B_BAND] = xb_reg[B_HI] - ONE_C;
                yb_next[B_BAND] = yb_reg[B_HI] - ONE_C;
            end
            S_SWEEP:
            begin
                if (last_col)
                begin
                    col_next  = '0;
                    row_next  = row_reg + IDX_W'(1);
                    base_next = base_reg + ADDR_W'(MAX_SIDE);
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            S_RDADDR:
            begin
                addr_next = ADDR_W'(PROD_W'(rrow_reg) * PROD_W'(MAX_SIDE) + PROD_W'(rcol_reg));
                if (outside)
                begin
                    res_status_next = ST_RANGE;
                end
                else
                begin
                    res_rd_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pixel_next  = res_rd_reg ? rdata_reg : '0;
                end
            end
            default:
            begin
                res_rd_next = res_rd_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fw_reg        <= WIDTH_RST;
            fh_reg        <= HEIGHT_RST;
            bg_reg        <= BACKGROUND_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIDTH:      fw_reg <= cfg_data;
                    REG_HEIGHT:     fh_reg <= cfg_data;
                    REG_BACKGROUND: bg_reg <= cfg_data[PIX_W-1:0];
                    default:        fw_reg <= fw_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        outline_reg    <= outline_next;
        color_reg      <= color_next;
        rrow_reg       <= rrow_next;
        rcol_reg       <= rcol_next;
        xb_reg         <= xb_next;
        yb_reg         <= yb_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        base_reg       <= base_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        out_status_reg <= out_status_next;
        out_pixel_reg  <= out_pixel_next;
    end

    // frame memory, one write port for the sweep and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_RDMEM)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    `RRF_ASSERT_IMPL(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == S_IDLE)
    `RRF_ASSERT_IMPL(a_write_sweep, clk, rst_n, wr_en, state_reg == S_SWEEP)
    `RRF_ASSERT_NEXT(a_sweep_end, clk, rst_n,
        (state_reg == S_SWEEP) && last_col && last_row, state_reg == S_DONE)
    `RRF_ASSERT_NEXT(a_read_start, clk, rst_n,
        s_xfer && (s_axis_tuser == ACT_READ), state_reg == S_RDADDR)

endmodule

### dv/rectangle_raster_fill_checker.sv
`timescale 1ns / 1ps

module rectangle_raster_fill_checker
    import rrf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // rect_x, rect_y, rect_width, rect_height, outline, color, read_row, read_col
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [1:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, pixel
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    mismatch_count,
    output int                    pending_count
);

    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_PIXEL_LSB  = 2;

    typedef struct packed {
        logic [1:0]       status;
        logic [PIX_W-1:0] pixel;
    } reply_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] bg_reg;
    logic [PIX_W-1:0] frame_mem [MAX_SIDE_DEF * MAX_SIDE_DEF];
    reply_t           pending_replies [$];

    function automatic int effective_side(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
        return int'(v);
    endfunction

    // applies one action to the frame copy and returns the reply it gives
    function automatic reply_t raster_action(input logic [1:0] act,
                                             input logic [IN_DATA_W-1:0] d);
        longint x, y, rw, rh, px, py, right, bottom, one;
        int     fw, fh, r, c, row, col;
        logic   in_rect, border, edge_only;
        reply_t rep;
        rep = '0;
        fw = effective_side(width_reg);
        fh = effective_side(height_reg);
        one = longint'(1) << FRAC_BITS_DEF;
        case (act)
            ACT_CLEAR:
            begin
                for (r = 0; r < fh; r++)
                    for (c = 0; c < fw; c++)
                        frame_mem[r * MAX_SIDE_DEF + c] = bg_reg;
            end
            ACT_DRAW:
            begin
                x  = longint'($signed(d[IN_X_LSB +: COORD_W]));
                y  = longint'($signed(d[IN_Y_LSB +: COORD_W]));
                rw = longint'($signed(d[IN_W_LSB +: COORD_W]));
                rh = longint'($signed(d[IN_H_LSB +: COORD_W]));
                edge_only = d[IN_OUTLINE_BIT];
                right  = x + rw;
                bottom = y + rh;
                if (rw <= 0 || rh <= 0)
                    rep.status = ST_SIZE;
                else
                begin
                    for (r = 0; r < fh; r++)
                    begin
                        for (c = 0; c < fw; c++)
                        begin
                            px = longint'(c) * one;
                            py = longint'(r) * one;
                            in_rect = px >= x && py >= y && px <= right && py <= bottom;
                            // border band: closer than one unit to any edge
                            border = in_rect && (px - x < one || py - y < one ||
                                                 right - px < one || bottom - py < one);
                            if (edge_only ? border : in_rect)
                                frame_mem[r * MAX_SIDE_DEF + c] = d[IN_COLOR_LSB +: PIX_W];
                        end
                    end
                end
            end
            ACT_READ:
            begin
                row = int'(d[IN_ROW_LSB +: POS_W]);
                col = int'(d[IN_COL_LSB +: POS_W]);
                if (row >= fh || col >= fw)
                    rep.status = ST_RANGE;
                else
                    rep.pixel = frame_mem[row * MAX_SIDE_DEF + col];
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        reply_t got;
        reply_t want;
        int     errs;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            bg_reg     = BACKGROUND_RST;
            pending_replies.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIDTH:      width_reg  = cfg_data;
                    REG_HEIGHT:     height_reg = cfg_data;
                    REG_BACKGROUND: bg_reg     = cfg_data[PIX_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[OUT_STATUS_LSB +: 2];
                got.pixel  = m_axis_tdata[OUT_PIXEL_LSB +: PIX_W];
                if (pending_replies.size() == 0)
                begin
                    $error("result transfer with none awaited: status %0d, pixel %0d",
                           got.status, got.pixel);
                    errs++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.pixel !== want.pixel)
                    begin
                        $error("pixel: expected %0d, actual %0d", want.pixel, got.pixel);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_replies.push_back(raster_action(s_axis_tuser, s_axis_tdata));
            mismatch_count <= mismatch_count + errs;
            pending_count  <= pending_replies.size();
        end
    end

endmodule

### dv/rectangle_raster_fill_core_tb.sv
`timescale 1ns / 1ps

module rectangle_raster_fill_core_tb;

    import rrf_pkg::*;

    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int ONE_Q        = 1 << FRAC_BITS_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 60;
    localparam int RANDOM_PHASES = 5;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int   mismatch_count;
    int   pending_count;
    int   stall_cycles = 0;
    int   send_gap_max = 6;
    int   recv_gap_max = 6;
    logic hold_request = 1'b0;
    int   act_w;
    int   act_h;

    rectangle_raster_fill_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rectangle_raster_fill_checker raster_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    // any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic int effective_side(input int value);
        int v;
        v = value & 'h1FF;
        if (v == 0)
            return 1;
        if (v > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
        return v;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(
        input logic [COORD_W-1:0] x, y, w, h,
        input logic outline,
        input logic [PIX_W-1:0] color,
        input logic [POS_W-1:0] row, col);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IN_X_LSB +: COORD_W]  = x;
        d[IN_Y_LSB +: COORD_W]  = y;
        d[IN_W_LSB +: COORD_W]  = w;
        d[IN_H_LSB +: COORD_W]  = h;
        d[IN_OUTLINE_BIT]       = outline;
        d[IN_COLOR_LSB +: PIX_W] = color;
        d[IN_ROW_LSB +: POS_W]  = row;
        d[IN_COL_LSB +: POS_W]  = col;
        return d;
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [IN_DATA_W-1:0] d);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  = act;
        s_axis_tdata  = d;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // fields an action ignores carry random content
    task automatic send_clear;
        send_item(ACT_CLEAR, pack_item(COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom), 1'($urandom),
                  PIX_W'($urandom), POS_W'($urandom), POS_W'($urandom)));
    endtask

    task automatic send_draw(input int x, y, w, h, input logic outline, input int color);
        send_item(ACT_DRAW, pack_item(COORD_W'(x), COORD_W'(y), COORD_W'(w), COORD_W'(h),
                  outline, PIX_W'(color), POS_W'($urandom), POS_W'($urandom)));
    endtask

    task automatic send_read(input int row, col);
        send_item(ACT_READ, pack_item(COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom), 1'($urandom),
                  PIX_W'($urandom), POS_W'(row), POS_W'(col)));
    endtask

    task automatic send_unused_action;
        send_item(ACT_NONE, pack_item(COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom), 1'($urandom),
                  PIX_W'($urandom), POS_W'($urandom), POS_W'($urandom)));
    endtask

    // rectangle around the active frame, edges often on fractional positions
    task automatic draw_in_frame;
        int x_q, y_q, w_q, h_q;
        x_q = $urandom_range(0, (act_w + 4) * ONE_Q) - 2 * ONE_Q;
        y_q = $urandom_range(0, (act_h + 4) * ONE_Q) - 2 * ONE_Q;
        if ($urandom_range(0, 1))
        begin
            w_q = $urandom_range(1, 3 * ONE_Q);
            h_q = $urandom_range(1, 3 * ONE_Q);
        end
        else
        begin
            w_q = $urandom_range(1, (act_w + 2) * ONE_Q);
            h_q = $urandom_range(1, (act_h + 2) * ONE_Q);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            x_q = x_q & ~(ONE_Q - 1);
            y_q = y_q & ~(ONE_Q - 1);
            w_q = (w_q < ONE_Q) ? ONE_Q : (w_q & ~(ONE_Q - 1));
            h_q = (h_q < ONE_Q) ? ONE_Q : (h_q & ~(ONE_Q - 1));
        end
        send_draw(x_q, y_q, w_q, h_q, 1'($urandom), $urandom_range(0, 255));
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = CFG_W'(value);
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == REG_WIDTH)
            act_w = effective_side(value);
        else if (idx == REG_HEIGHT)
            act_h = effective_side(value);
    endtask

    task automatic wait_idle;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // result side: random hold-off per transfer, one long hold on request
    initial
    begin
        int gap;
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin
        int phase, items, kind, n, row, col;
        logic [COORD_W-1:0] bad_side;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_CLEAR;
        cfg_valid     = 1'b0;
        cfg_index     = REG_WIDTH;
        cfg_data      = '0;
        act_w         = effective_side(int'(WIDTH_RST));
        act_h         = effective_side(int'(HEIGHT_RST));
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset frame of one pixel
        send_clear;
        send_read(0, 0);
        send_read(0, 1);
        send_draw(0, 0, ONE_Q, ONE_Q, 1'b0, 'hA5);
        send_read(0, 0);
        send_draw(0, 0, 0, ONE_Q, 1'b0, 'h33);
        send_unused_action;

        // zero sizes act as one, index past the register list
        wait_idle;
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_BACKGROUND, 255);
        write_reg(REG_UNUSED, 'h1FF);
        send_clear;
        send_read(0, 0);
        send_read(0, 1);

        wait_idle;
        write_reg(REG_WIDTH, 8);
        write_reg(REG_HEIGHT, 6);
        write_reg(REG_BACKGROUND, 0);
        send_clear;
        // outline on cols 2..5, rows 1..3: edges at 1.5, 5.5, 0.5, 3.5
        send_draw('h180, 'h080, 'h400, 'h300, 1'b1, 'hFF);
        send_read(1, 3);
        send_read(2, 3);
        // coordinate extremes: the first two rectangles miss the frame, the third has a negative height
        send_draw('h80000, 'h80000, 'h7FFFF, 'h7FFFF, 1'b0, 'h5A);
        send_draw('h7FFFF, 0, 'h7FFFF, ONE_Q, 1'b1, 'h11);
        send_draw(0, 0, ONE_Q, 'h80000, 1'b0, 'h22);
        send_read(6, 0);
        send_read(0, 8);

        // width above the largest side
        wait_idle;
        write_reg(REG_WIDTH, 511);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_BACKGROUND, 'h3C);
        send_clear;
        send_draw('hFE80, 0, 2 * ONE_Q, ONE_Q, 1'b0, 'hE7);
        send_read(0, 255);
        send_read(1, 0);

        wait_idle;
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 300);
        send_clear;
        send_read(255, 0);

        // full frame
        wait_idle;
        write_reg(REG_WIDTH, MAX_SIDE_DEF);
        write_reg(REG_HEIGHT, MAX_SIDE_DEF);
        write_reg(REG_BACKGROUND, 'h96);
        send_clear;
        send_draw(0, 0, 255 * ONE_Q, 255 * ONE_Q, 1'b1, 'hC3);
        send_read(255, 255);
        send_read(128, 128);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle;
            send_gap_max = (phase == 3) ? 0 : 6;
            recv_gap_max = (phase == 3) ? 0 : 6;
            write_reg(REG_WIDTH, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12));
            write_reg(REG_HEIGHT, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12));
            write_reg(REG_BACKGROUND, $urandom_range(0, 255));
            // every active pixel written before any read
            send_clear;
            // results back up while items keep coming
            if (phase == 1)
                hold_request = 1'b1;
            items = 0;
            while (items < RANDOM_ITEMS / RANDOM_PHASES)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 5)
                begin
                    draw_in_frame;
                    n = $urandom_range(2, 5);
                    repeat (n)
                        send_read($urandom_range(0, act_h - 1), $urandom_range(0, act_w - 1));
                    items += n + 1;
                end
                else if (kind == 6)
                begin
                    wait_idle;
                    send_clear;
                    items++;
                end
                else if (kind == 7)
                begin
                    bad_side = COORD_W'($urandom);
                    bad_side[COORD_W-1] = 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        bad_side = '0;
                    if ($urandom_range(0, 1))
                        send_draw($urandom, $urandom, bad_side, $urandom, 1'($urandom),
                                  $urandom_range(0, 255));
                    else
                        send_draw($urandom, $urandom, $urandom, bad_side, 1'($urandom),
                                  $urandom_range(0, 255));
                    items++;
                end
                else if (kind == 8)
                begin
                    send_draw($urandom, $urandom, $urandom, $urandom, 1'($urandom),
                              $urandom_range(0, 255));
                    items++;
                end
                else if ($urandom_range(0, 1))
                begin
                    row = $urandom_range(0, 255);
                    col = $urandom_range(0, 255);
                    if (row < act_h && col < act_w)
                        row = $urandom_range(act_h, 255);
                    send_read(row, col);
                    items++;
                end
                else
                begin
                    send_unused_action;
                    items++;
                end
            end
        end

        wait_idle;
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
